// ===== src/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int PATTERN_BYTES       = 16;
   localparam int BYTE_WIDTH          = 8;
   localparam int LENGTH_WIDTH        = 5;
   localparam int WORD_WIDTH          = 64;
   localparam int OFFSET_WIDTH        = 48;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int PATTERN_INDEX_WIDTH = $clog2(PATTERN_BYTES);

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [PATTERN_BYTES-1:0][BYTE_WIDTH-1:0] pattern_bytes_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_LENGTH    = 2'd0,
      CSR_PATTERN_LOW_WORD  = 2'd1,
      CSR_PATTERN_HIGH_WORD = 2'd2
   } csr_index_type;

   localparam offset_type OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

endpackage

`default_nettype wire

// ===== src/bps_if.sv =====
`default_nettype none

interface bps_req_if;
   logic               valid;
   logic               ready;
   bps_pkg::byte_type  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bps_rsp_if;
   logic                valid;
   logic                ready;
   bps_pkg::offset_type match_start;

   modport source (output valid, output match_start, input ready);
   modport sink   (input valid, input match_start, output ready);
endinterface

`default_nettype wire

// ===== src/bps_window.sv =====
`default_nettype none

module bps_window #(
   parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEFAULT,
   localparam int LEN_W = $clog2(MAX_PATTERN + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire bps_pkg::byte_type          data_byte,
   input  wire logic [LEN_W-1:0]           used_len,
   input  wire bps_pkg::pattern_bytes_type pattern,
   output logic                            hit
);

   bps_pkg::byte_type window_ff [MAX_PATTERN];
   bps_pkg::byte_type window_in [MAX_PATTERN];
   logic [LEN_W-1:0]  fill_ff;
   logic [LEN_W-1:0]  fill_in;

   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (fill_ff < LEN_W'(MAX_PATTERN)) begin
         fill_in = fill_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (shift_en) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         window_ff <= window_in;
      end
   end

   // compare entry k with pattern byte (length - 1 - k)
   always_comb begin
      logic [LEN_W-1:0]                        diff;
      logic [bps_pkg::PATTERN_INDEX_WIDTH-1:0] pidx;
      hit = (fill_ff >= used_len);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         diff = used_len - LEN_W'(1) - LEN_W'(k);
         pidx = bps_pkg::PATTERN_INDEX_WIDTH'(diff);
         if ((LEN_W'(k) < used_len) && (window_ff[k] != pattern[pidx])) begin
            hit = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/byte_pattern_search_unit.sv =====
// Byte pattern search unit.
// Bytes of a stream enter on req_if (valid/ready); for every place where the
// configured pattern of 1 to 16 bytes ends, overlaps included, one item with
// the stream offset of the pattern's first byte leaves on rsp_if.
// The pattern is set through the csr_ write port: index 0 is the length,
// index 1 bytes 0..7, index 2 bytes 8..15 (lowest byte first). Write it only
// while the stream is idle; the byte window and offset are kept across writes.
// Throughput: one byte per cycle while rsp_if does not stall, set by the
// window shift and parallel compare of all window entries.
// Path: an accepted byte is registered in the compare stage, and its result
// moves on into the output register, valid on rsp_if (two registers deep).
// Stall: while a result waits on rsp_if, the compare stage can still take
// one more byte; after that req_if.ready stays low until rsp_if.ready.
// Reset (synchronous, active high) empties both stages, clears the window
// fill count and the byte offset, and sets length 1 and an all-zero pattern.
// The offset saturates at 2^48-1.
`default_nettype none

module byte_pattern_search_unit #(
   parameter int MAX_PATTERN = bps_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   bps_req_if.sink                                    req_if,
   bps_rsp_if.source                                  rsp_if,
   input  wire logic                                  csr_write_enable,
   input  wire logic [bps_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [bps_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [bps_pkg::LENGTH_WIDTH-1:0] length_ff;
   logic [bps_pkg::WORD_WIDTH-1:0]   low_word_ff;
   logic [bps_pkg::WORD_WIDTH-1:0]   high_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= bps_pkg::LENGTH_WIDTH'(1);
         low_word_ff  <= '0;
         high_word_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            bps_pkg::CSR_PATTERN_LENGTH: begin
               length_ff <= csr_write_data[bps_pkg::LENGTH_WIDTH-1:0];
            end
            bps_pkg::CSR_PATTERN_LOW_WORD: begin
               low_word_ff <= csr_write_data;
            end
            bps_pkg::CSR_PATTERN_HIGH_WORD: begin
               high_word_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   logic [LEN_W-1:0]           used_len;
   bps_pkg::pattern_bytes_type pattern;

   always_comb begin
      if (length_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (length_ff > bps_pkg::LENGTH_WIDTH'(MAX_PATTERN)) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = LEN_W'(length_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < bps_pkg::PATTERN_BYTES / 2; i++) begin
         pattern[i] = low_word_ff[i*bps_pkg::BYTE_WIDTH +: bps_pkg::BYTE_WIDTH];
         pattern[i + bps_pkg::PATTERN_BYTES / 2] =
            high_word_ff[i*bps_pkg::BYTE_WIDTH +: bps_pkg::BYTE_WIDTH];
      end
   end

   logic                s1_valid_ff;
   bps_pkg::offset_type s1_here_ff;
   bps_pkg::offset_type offset_ff;
   bps_pkg::offset_type offset_in;
   logic                rsp_valid_ff;
   bps_pkg::offset_type rsp_start_ff;
   bps_pkg::offset_type rsp_start_in;
   logic                out_ready;
   logic                s1_advance;
   logic                accept;
   logic                hit;

   assign out_ready  = !rsp_valid_ff || rsp_if.ready;
   assign s1_advance = s1_valid_ff && out_ready;
   assign req_if.ready = !s1_valid_ff || out_ready;
   assign accept     = req_if.valid && req_if.ready;

   assign offset_in    = (offset_ff == bps_pkg::OFFSET_MAX) ? offset_ff
                         : offset_ff + bps_pkg::OFFSET_WIDTH'(1);
   assign rsp_start_in = s1_here_ff - bps_pkg::OFFSET_WIDTH'(used_len - LEN_W'(1));

   bps_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (accept),
      .data_byte (req_if.data_byte),
      .used_len  (used_len),
      .pattern   (pattern),
      .hit       (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            offset_ff   <= offset_in;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff && hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_here_ff <= offset_ff;
      end
      if (out_ready) begin
         rsp_start_ff <= rsp_start_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.match_start = rsp_start_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ready |=> s1_valid_ff && $stable(s1_here_ff))
      else $error("compare stage lost its item while the output was stalled");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff && (s1_here_ff == $past(offset_ff)))
      else $error("accepted item missing from compare stage");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff) && $past(hit))
      else $error("result appeared without a matching item");

endmodule

`default_nettype wire
